/* rtl/core/ladrc_pkg.sv */
// ============================================================================
// ladrc_pkg
// Shared types and constants of the ADRC position loop: register indexes,
// reset values, fixed field widths and the state encodings.
// ============================================================================
package ladrc_pkg;

  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned TARGET_W  = 31;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned DRIVE_W   = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int unsigned SCALED_W  = 33;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned REG_IDX_W = 3;
  localparam int          DEADBAND  = 292818;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;

  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BETA1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BETA2  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BETA3  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BGAIN  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BRECIP = 3'd7;

  localparam logic [GAIN_W-1:0] RST_PROP   = 32'd5120;
  localparam logic [GAIN_W-1:0] RST_RATE   = 32'd0;
  localparam logic [GAIN_W-1:0] RST_BETA1  = 32'd53760;
  localparam logic [GAIN_W-1:0] RST_BETA2  = 32'd3763200;
  localparam logic [GAIN_W-1:0] RST_BETA3  = 32'd87808000;
  localparam logic [GAIN_W-1:0] RST_BGAIN  = 32'd3840;
  localparam logic [GAIN_W-1:0] RST_BRECIP = 32'd17476;

  typedef enum logic [1:0] {
    SH_8,
    SH_16,
    SH_24
  } shift_e;

  typedef struct packed {
    logic   start;
    shift_e shift;
  } mul_ctrl_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic [GAIN_W-1:0]          kp;
    logic [GAIN_W-1:0]          kd;
    logic [GAIN_W-1:0]          beta1;
    logic [GAIN_W-1:0]          beta2;
    logic [GAIN_W-1:0]          beta3;
    logic [GAIN_W-1:0]          bgain;
    logic [GAIN_W-1:0]          brecip;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_CLIP,
    MUL_SIGN,
    MUL_DONE
  } mul_state_e;

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_SCALE,
    SEQ_ANGLE,
    SEQ_EPS,
    SEQ_M1,
    SEQ_A1,
    SEQ_D1,
    SEQ_Z1,
    SEQ_M2,
    SEQ_A2,
    SEQ_M4,
    SEQ_A3,
    SEQ_D2,
    SEQ_Z2,
    SEQ_M3,
    SEQ_A4,
    SEQ_D3,
    SEQ_Z3,
    SEQ_ERR,
    SEQ_U1,
    SEQ_A5,
    SEQ_U2,
    SEQ_A6,
    SEQ_U3,
    SEQ_A7,
    SEQ_OUT
  } seq_state_e;

endpackage

/* rtl/core/ladrc_digit_mul.sv */
// ============================================================================
// ladrc_digit_mul
// Digit-serial sign-magnitude multiplier: signed state value times an unsigned
// 32-bit gain, one 4-bit gain digit per cycle, then shift, clip and sign.
// ============================================================================
module ladrc_digit_mul #(
  parameter int unsigned STATE_WIDTH = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ladrc_pkg::mul_ctrl_t          ctrl_i,
  input  logic signed [STATE_WIDTH-1:0] operand_i,
  input  logic [ladrc_pkg::GAIN_W-1:0]  gain_i,
  output logic                          done_o,
  output logic signed [STATE_WIDTH-1:0] result_o
);

  localparam int unsigned AW    = STATE_WIDTH + ladrc_pkg::GAIN_W;
  localparam int unsigned PW    = STATE_WIDTH + ladrc_pkg::DIGIT_W;
  localparam int unsigned CNT_W = $clog2(ladrc_pkg::NUM_DIGITS);
  localparam logic [STATE_WIDTH-1:0] MAG_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};

  ladrc_pkg::mul_state_e state_q, state_d;

  logic [STATE_WIDTH-1:0]           mag_q;
  logic                             neg_q;
  logic [ladrc_pkg::GAIN_W-1:0]     gain_q;
  logic [AW-1:0]                    acc_q;
  logic [CNT_W-1:0]                 cnt_q;
  ladrc_pkg::shift_e                shift_q;
  logic [STATE_WIDTH-1:0]           clip_q;
  logic signed [STATE_WIDTH-1:0]    result_q;

  logic                             load;
  logic                             step;
  logic [ladrc_pkg::DIGIT_W-1:0]    digit;
  logic [PW-1:0]                    part;
  logic [AW-1:0]                    shifted;
  logic [STATE_WIDTH-1:0]           lim;
  logic [STATE_WIDTH-1:0]           clip;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ladrc_pkg::MUL_IDLE: if (ctrl_i.start) state_d = ladrc_pkg::MUL_RUN;
      ladrc_pkg::MUL_RUN:  if (cnt_q == '0) state_d = ladrc_pkg::MUL_CLIP;
      ladrc_pkg::MUL_CLIP: state_d = ladrc_pkg::MUL_SIGN;
      ladrc_pkg::MUL_SIGN: state_d = ladrc_pkg::MUL_DONE;
      ladrc_pkg::MUL_DONE: state_d = ladrc_pkg::MUL_IDLE;
      default:             state_d = ladrc_pkg::MUL_IDLE;
    endcase
  end

  always_comb begin
    load   = (state_q == ladrc_pkg::MUL_IDLE) && ctrl_i.start;
    step   = (state_q == ladrc_pkg::MUL_RUN);
    done_o = (state_q == ladrc_pkg::MUL_DONE);
  end

  assign digit = gain_q[ladrc_pkg::GAIN_W-1 -: ladrc_pkg::DIGIT_W];
  assign part  = PW'(mag_q) * PW'(digit);

  always_comb begin
    unique case (shift_q)
      ladrc_pkg::SH_8:  shifted = acc_q >> 8;
      ladrc_pkg::SH_16: shifted = acc_q >> 16;
      ladrc_pkg::SH_24: shifted = acc_q >> 24;
      default:          shifted = acc_q >> 24;
    endcase
    lim  = MAG_MAX + STATE_WIDTH'(neg_q);
    clip = (shifted > AW'(lim)) ? lim : shifted[STATE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ladrc_pkg::MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q   <= operand_i[STATE_WIDTH-1];
      mag_q   <= operand_i[STATE_WIDTH-1] ? (STATE_WIDTH'(0) - operand_i) : operand_i;
      gain_q  <= gain_i;
      acc_q   <= '0;
      cnt_q   <= CNT_W'(ladrc_pkg::NUM_DIGITS - 1);
      shift_q <= ctrl_i.shift;
    end else if (step) begin
      acc_q  <= (acc_q << ladrc_pkg::DIGIT_W) + AW'(part);
      gain_q <= gain_q << ladrc_pkg::DIGIT_W;
      cnt_q  <= cnt_q - 1'b1;
    end
    if (state_q == ladrc_pkg::MUL_CLIP) begin
      clip_q <= clip;
    end
    if (state_q == ladrc_pkg::MUL_SIGN) begin
      result_q <= neg_q ? (STATE_WIDTH'(0) - clip_q) : clip_q;
    end
  end

  assign result_o = result_q;

endmodule

/* rtl/core/ladrc_eso_seq.sv */
// ============================================================================
// ladrc_eso_seq
// Sequencer of the observer and drive law: holds z1, z2, z3 and the last
// drive, runs the saturating adder and issues requests to the multiplier.
// ============================================================================
module ladrc_eso_seq #(
  parameter int unsigned STATE_WIDTH  = 48,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic [ladrc_pkg::TIME_W-1:0]          elapsed_i,
  input  ladrc_pkg::cfg_t                       cfg_i,
  input  logic                                  out_free_i,
  output logic                                  idle_o,
  output logic                                  done_o,
  output logic signed [ladrc_pkg::DRIVE_W-1:0]  drive_o,
  output logic signed [STATE_WIDTH-1:0]         angle_est_o,
  output logic signed [STATE_WIDTH-1:0]         dist_est_o,
  output logic                                  band_o
);

  localparam int unsigned W        = STATE_WIDTH;
  localparam int unsigned SW       = ladrc_pkg::SCALED_W;
  localparam int unsigned XW       = (W > SW) ? W : SW;
  localparam int unsigned SCALE_SH = 25 - SAMPLE_WIDTH;
  localparam logic signed [W-1:0] ST_MAX     = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] ST_MIN     = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] TRUNC_BIAS = W'((1 << ladrc_pkg::FRAC_W) - 1);
  localparam logic signed [W-1:0] Q_MAX      = W'(32767);
  localparam logic signed [W-1:0] Q_MIN      = W'(-32768);

  function automatic logic signed [W-1:0] clamp_state(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] vx;
    vx = XW'(v);
    if (vx > XW'(ST_MAX)) return ST_MAX;
    if (vx < XW'(ST_MIN)) return ST_MIN;
    return W'(vx);
  endfunction

  ladrc_pkg::seq_state_e state_q, state_d;
  logic issued_q, issued_d;

  logic signed [SAMPLE_WIDTH-1:0]   raw_q;
  logic [ladrc_pkg::TIME_W-1:0]     dt_q;
  logic signed [SW-1:0]             scaled_q;
  logic signed [W-1:0]              angle_q;
  logic signed [W-1:0]              target_q;
  logic                             band_q;
  logic signed [W-1:0]              eps_q;
  logic signed [W-1:0]              t_q;
  logic signed [W-1:0]              u_q;
  logic signed [W-1:0]              z1_q;
  logic signed [W-1:0]              z2_q;
  logic signed [W-1:0]              z3_q;
  logic signed [W-1:0]              ld_q;

  logic signed [W-1:0]              alu_a;
  logic signed [W-1:0]              alu_b;
  logic                             alu_sub;
  logic signed [W:0]                alu_sum;
  logic signed [W-1:0]              alu_res;

  logic                             mul_req;
  ladrc_pkg::shift_e                mul_shift;
  ladrc_pkg::mul_ctrl_t             mul_ctrl;
  logic signed [W-1:0]              mul_operand;
  logic [ladrc_pkg::GAIN_W-1:0]     mul_gain;
  logic                             mul_done;
  logic signed [W-1:0]              mul_result;

  logic signed [SW-1:0]             raw_x;
  logic signed [SW-1:0]             raw_180;
  logic signed [SW-1:0]             target4;
  logic signed [SW:0]               diff;
  logic signed [W-1:0]              u_bias;
  logic signed [W-1:0]              q_w;

  ladrc_digit_mul #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mul_ctrl),
    .operand_i (mul_operand),
    .gain_i    (mul_gain),
    .done_o    (mul_done),
    .result_o  (mul_result)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ladrc_pkg::SEQ_IDLE:  if (start_i) state_d = ladrc_pkg::SEQ_SCALE;
      ladrc_pkg::SEQ_SCALE: state_d = ladrc_pkg::SEQ_ANGLE;
      ladrc_pkg::SEQ_ANGLE: state_d = ladrc_pkg::SEQ_EPS;
      ladrc_pkg::SEQ_EPS:   state_d = ladrc_pkg::SEQ_M1;
      ladrc_pkg::SEQ_M1:    if (mul_done) state_d = ladrc_pkg::SEQ_A1;
      ladrc_pkg::SEQ_A1:    state_d = ladrc_pkg::SEQ_D1;
      ladrc_pkg::SEQ_D1:    if (mul_done) state_d = ladrc_pkg::SEQ_Z1;
      ladrc_pkg::SEQ_Z1:    state_d = ladrc_pkg::SEQ_M2;
      ladrc_pkg::SEQ_M2:    if (mul_done) state_d = ladrc_pkg::SEQ_A2;
      ladrc_pkg::SEQ_A2:    state_d = ladrc_pkg::SEQ_M4;
      ladrc_pkg::SEQ_M4:    if (mul_done) state_d = ladrc_pkg::SEQ_A3;
      ladrc_pkg::SEQ_A3:    state_d = ladrc_pkg::SEQ_D2;
      ladrc_pkg::SEQ_D2:    if (mul_done) state_d = ladrc_pkg::SEQ_Z2;
      ladrc_pkg::SEQ_Z2:    state_d = ladrc_pkg::SEQ_M3;
      ladrc_pkg::SEQ_M3:    if (mul_done) state_d = ladrc_pkg::SEQ_A4;
      ladrc_pkg::SEQ_A4:    state_d = ladrc_pkg::SEQ_D3;
      ladrc_pkg::SEQ_D3:    if (mul_done) state_d = ladrc_pkg::SEQ_Z3;
      ladrc_pkg::SEQ_Z3:    state_d = ladrc_pkg::SEQ_ERR;
      ladrc_pkg::SEQ_ERR:   state_d = ladrc_pkg::SEQ_U1;
      ladrc_pkg::SEQ_U1:    if (mul_done) state_d = ladrc_pkg::SEQ_A5;
      ladrc_pkg::SEQ_A5:    state_d = ladrc_pkg::SEQ_U2;
      ladrc_pkg::SEQ_U2:    if (mul_done) state_d = ladrc_pkg::SEQ_A6;
      ladrc_pkg::SEQ_A6:    state_d = ladrc_pkg::SEQ_U3;
      ladrc_pkg::SEQ_U3:    if (mul_done) state_d = ladrc_pkg::SEQ_A7;
      ladrc_pkg::SEQ_A7:    state_d = ladrc_pkg::SEQ_OUT;
      ladrc_pkg::SEQ_OUT:   if (out_free_i) state_d = ladrc_pkg::SEQ_IDLE;
      default:              state_d = ladrc_pkg::SEQ_IDLE;
    endcase
  end

  // outputs: adder operands and multiplier requests
  always_comb begin
    alu_a       = '0;
    alu_b       = mul_result;
    alu_sub     = 1'b0;
    mul_req     = 1'b0;
    mul_operand = eps_q;
    mul_gain    = cfg_i.beta1;
    mul_shift   = ladrc_pkg::SH_8;
    unique case (state_q) inside
      ladrc_pkg::SEQ_EPS: begin
        alu_a   = z1_q;
        alu_b   = angle_q;
        alu_sub = 1'b1;
      end
      ladrc_pkg::SEQ_M1: begin
        mul_req = 1'b1;
      end
      ladrc_pkg::SEQ_A1: begin
        alu_a   = z2_q;
        alu_sub = 1'b1;
      end
      ladrc_pkg::SEQ_D1, ladrc_pkg::SEQ_D2, ladrc_pkg::SEQ_D3: begin
        mul_req     = 1'b1;
        mul_operand = t_q;
        mul_gain    = ladrc_pkg::GAIN_W'(dt_q);
        mul_shift   = ladrc_pkg::SH_16;
      end
      ladrc_pkg::SEQ_Z1: begin
        alu_a = z1_q;
      end
      ladrc_pkg::SEQ_M2: begin
        mul_req  = 1'b1;
        mul_gain = cfg_i.beta2;
      end
      ladrc_pkg::SEQ_A2: begin
        alu_a   = z3_q;
        alu_sub = 1'b1;
      end
      ladrc_pkg::SEQ_M4: begin
        mul_req     = 1'b1;
        mul_operand = ld_q;
        mul_gain    = cfg_i.bgain;
      end
      ladrc_pkg::SEQ_A3: begin
        alu_a = t_q;
      end
      ladrc_pkg::SEQ_Z2: begin
        alu_a = z2_q;
      end
      ladrc_pkg::SEQ_M3: begin
        mul_req  = 1'b1;
        mul_gain = cfg_i.beta3;
      end
      ladrc_pkg::SEQ_A4: begin
        alu_sub = 1'b1;
      end
      ladrc_pkg::SEQ_Z3: begin
        alu_a = z3_q;
      end
      ladrc_pkg::SEQ_ERR: begin
        alu_a   = target_q;
        alu_b   = z1_q;
        alu_sub = 1'b1;
      end
      ladrc_pkg::SEQ_U1: begin
        mul_req     = 1'b1;
        mul_operand = t_q;
        mul_gain    = cfg_i.kp;
      end
      ladrc_pkg::SEQ_U2: begin
        mul_req     = 1'b1;
        mul_operand = z2_q;
        mul_gain    = cfg_i.kd;
      end
      ladrc_pkg::SEQ_U3: begin
        mul_req     = 1'b1;
        mul_operand = z3_q;
        mul_gain    = cfg_i.brecip;
        mul_shift   = ladrc_pkg::SH_24;
      end
      ladrc_pkg::SEQ_A6, ladrc_pkg::SEQ_A7: begin
        alu_a   = u_q;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
    mul_ctrl.start = mul_req && !issued_q;
    mul_ctrl.shift = mul_shift;
    issued_d       = mul_done ? 1'b0 : (issued_q || mul_ctrl.start);
    idle_o         = (state_q == ladrc_pkg::SEQ_IDLE);
    done_o         = (state_q == ladrc_pkg::SEQ_OUT) && out_free_i;
  end

  // saturating adder
  always_comb begin
    if (alu_sub) begin
      alu_sum = (W+1)'(alu_a) - (W+1)'(alu_b);
    end else begin
      alu_sum = (W+1)'(alu_a) + (W+1)'(alu_b);
    end
    if (alu_sum[W] != alu_sum[W-1]) begin
      alu_res = alu_sum[W] ? ST_MIN : ST_MAX;
    end else begin
      alu_res = alu_sum[W-1:0];
    end
  end

  // sample scaling: raw * 180 * 2^(25 - sample width)
  assign raw_x   = SW'(raw_q);
  assign raw_180 = (raw_x <<< 7) + (raw_x <<< 5) + (raw_x <<< 4) + (raw_x <<< 2);
  assign target4 = {cfg_i.target, 2'b00};
  assign diff    = (SW+1)'(target4) - (SW+1)'(scaled_q);

  // drive: zero inside the deadband, else truncate toward zero, saturate to 16 bits
  always_comb begin
    u_bias = u_q + (u_q[W-1] ? TRUNC_BIAS : '0);
    q_w    = u_bias >>> ladrc_pkg::FRAC_W;
    if (band_q) begin
      drive_o = '0;
    end else if (q_w > Q_MAX) begin
      drive_o = ladrc_pkg::DRIVE_MAX;
    end else if (q_w < Q_MIN) begin
      drive_o = ladrc_pkg::DRIVE_MIN;
    end else begin
      drive_o = q_w[ladrc_pkg::DRIVE_W-1:0];
    end
  end

  assign angle_est_o = z1_q;
  assign dist_est_o  = z3_q;
  assign band_o      = band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ladrc_pkg::SEQ_IDLE;
      issued_q <= 1'b0;
      z1_q     <= '0;
      z2_q     <= '0;
      z3_q     <= '0;
      ld_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      unique case (state_q)
        ladrc_pkg::SEQ_Z1:  z1_q <= alu_res;
        ladrc_pkg::SEQ_Z2:  z2_q <= alu_res;
        ladrc_pkg::SEQ_Z3:  z3_q <= alu_res;
        ladrc_pkg::SEQ_OUT: ld_q <= band_q ? '0 : u_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      ladrc_pkg::SEQ_IDLE: begin
        if (start_i) begin
          raw_q <= sample_i;
          dt_q  <= elapsed_i;
        end
      end
      ladrc_pkg::SEQ_SCALE: scaled_q <= raw_180 <<< SCALE_SH;
      ladrc_pkg::SEQ_ANGLE: begin
        angle_q  <= clamp_state(scaled_q);
        target_q <= clamp_state(target4);
        band_q   <= (diff < (SW+1)'(ladrc_pkg::DEADBAND)) &&
                    (diff > -((SW+1)'(ladrc_pkg::DEADBAND)));
      end
      ladrc_pkg::SEQ_EPS: eps_q <= alu_res;
      ladrc_pkg::SEQ_A1, ladrc_pkg::SEQ_A2, ladrc_pkg::SEQ_A3, ladrc_pkg::SEQ_A4,
      ladrc_pkg::SEQ_ERR: t_q <= alu_res;
      ladrc_pkg::SEQ_A5, ladrc_pkg::SEQ_A6, ladrc_pkg::SEQ_A7: u_q <= alu_res;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/linear_adrc_position_loop_unit.sv */
// ============================================================================
// linear_adrc_position_loop_unit
// Each request runs the sequencer through ten products on one shared 4-bit
// digit-serial multiplier. A new request is taken only once the sequencer is
// idle again; the next request is taken while a result still waits in the
// output register.
// Reset: observer state and last drive to zero, registers to their defaults.
// ============================================================================
module linear_adrc_position_loop_unit #(
  parameter int unsigned STATE_WIDTH  = 48,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // angle_sample, elapsed_time
  input  logic [((SAMPLE_WIDTH + 16 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // drive, angle_estimate, disturbance_estimate
  output logic [((16 + 2 * STATE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // in_deadband
  output logic [0:0]                                      m_axis_tuser,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  input  logic                                            cfg_we_i,
  input  logic [ladrc_pkg::REG_IDX_W-1:0]                 cfg_index_i,
  input  logic [ladrc_pkg::GAIN_W-1:0]                    cfg_wdata_i
);

  localparam int unsigned OUT_W = ((16 + 2 * STATE_WIDTH + 7) / 8) * 8;

  ladrc_pkg::cfg_t cfg_q;

  logic                                  seq_idle;
  logic                                  seq_done;
  logic                                  accept;
  logic                                  out_free;
  logic signed [ladrc_pkg::DRIVE_W-1:0]  seq_drive;
  logic signed [STATE_WIDTH-1:0]         seq_angle;
  logic signed [STATE_WIDTH-1:0]         seq_dist;
  logic                                  seq_band;

  logic                                  out_valid_q, out_valid_d;
  logic signed [ladrc_pkg::DRIVE_W-1:0]  out_drive_q;
  logic signed [STATE_WIDTH-1:0]         out_angle_q;
  logic signed [STATE_WIDTH-1:0]         out_dist_q;
  logic                                  out_band_q;

  assign s_axis_tready = seq_idle;
  assign accept        = s_axis_tvalid && seq_idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  ladrc_eso_seq #(
    .STATE_WIDTH  (STATE_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .elapsed_i   (s_axis_tdata[SAMPLE_WIDTH +: ladrc_pkg::TIME_W]),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .idle_o      (seq_idle),
    .done_o      (seq_done),
    .drive_o     (seq_drive),
    .angle_est_o (seq_angle),
    .dist_est_o  (seq_dist),
    .band_o      (seq_band)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target <= '0;
      cfg_q.kp     <= ladrc_pkg::RST_PROP;
      cfg_q.kd     <= ladrc_pkg::RST_RATE;
      cfg_q.beta1  <= ladrc_pkg::RST_BETA1;
      cfg_q.beta2  <= ladrc_pkg::RST_BETA2;
      cfg_q.beta3  <= ladrc_pkg::RST_BETA3;
      cfg_q.bgain  <= ladrc_pkg::RST_BGAIN;
      cfg_q.brecip <= ladrc_pkg::RST_BRECIP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ladrc_pkg::REG_TARGET: cfg_q.target <= cfg_wdata_i[ladrc_pkg::TARGET_W-1:0];
        ladrc_pkg::REG_PROP:   cfg_q.kp     <= cfg_wdata_i;
        ladrc_pkg::REG_RATE:   cfg_q.kd     <= cfg_wdata_i;
        ladrc_pkg::REG_BETA1:  cfg_q.beta1  <= cfg_wdata_i;
        ladrc_pkg::REG_BETA2:  cfg_q.beta2  <= cfg_wdata_i;
        ladrc_pkg::REG_BETA3:  cfg_q.beta3  <= cfg_wdata_i;
        ladrc_pkg::REG_BGAIN:  cfg_q.bgain  <= cfg_wdata_i;
        ladrc_pkg::REG_BRECIP: cfg_q.brecip <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_drive_q <= seq_drive;
      out_angle_q <= seq_angle;
      out_dist_q  <= seq_dist;
      out_band_q  <= seq_band;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_dist_q, out_angle_q, out_drive_q});
  assign m_axis_tuser  = out_band_q;

endmodule

/* verif/linear_adrc_position_loop_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADRC position loop testbench
// Streams yaw samples through the block and scores every result against a
// saturating fixed-point predictor of the observer and drive law. Directed
// extremes and deadband edges come first, then random sample runs under
// several register settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module linear_adrc_position_loop_unit_test;

  localparam longint STATE_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint STATE_MIN   = -STATE_MAX - 1;
  localparam longint DEG_SCALE   = 180 * 512;
  localparam longint BAND_OFFSET = 73204;
  localparam int     IDLE_LIMIT  = 2000;
  localparam int     DRAIN_WAIT  = 150;

  typedef struct {
    logic signed [ladrc_pkg::DRIVE_W-1:0] drive;
    logic signed [47:0]                   angle;
    logic signed [47:0]                   disturb;
    logic                                 deadband;
  } loop_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [ladrc_pkg::REG_IDX_W-1:0] cfg_index_i = '0;
  logic [ladrc_pkg::GAIN_W-1:0]    cfg_wdata_i = '0;

  ladrc_pkg::cfg_t loop_cfg;
  longint obs_angle, obs_rate, obs_dist, prev_drive;
  loop_result_t loop_outputs_due[$];
  loop_result_t head_due;

  int  errors;
  int  samples_sent;
  int  results_checked;
  int  settings_loaded;
  int  band_hits;
  int  idle_cycles;
  int  ready_hold;
  bit  tx_pacing;
  bit  rx_pacing;

  linear_adrc_position_loop_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint clip_state(longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clip_state(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clip_state(a - b);
  endfunction

  // magnitude product, truncated toward zero, clipped to the state range
  function automatic longint scale_mul(longint a, logic [31:0] g, int unsigned sh);
    logic [63:0] mag;
    logic [63:0] lim;
    logic [95:0] prod;
    mag  = (a < 0) ? -a : a;
    lim  = 64'(STATE_MAX) + ((a < 0) ? 64'd1 : 64'd0);
    prod = ({32'd0, mag} * {64'd0, g}) >> sh;
    if (prod > {32'd0, lim}) prod = {32'd0, lim};
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic loop_result_t advance_loop(logic signed [15:0] raw, logic [15:0] dt);
    longint       meas, err, z1, z2, z3, tgt, u, gap, q;
    logic [31:0]  step;
    loop_result_t r;
    step = {16'd0, dt};
    meas = clip_state(longint'(raw) * DEG_SCALE);
    err  = sub_sat(obs_angle, meas);
    z1 = add_sat(obs_angle,
                 scale_mul(sub_sat(obs_rate, scale_mul(err, loop_cfg.beta1, 8)), step, 16));
    z2 = add_sat(obs_rate,
                 scale_mul(add_sat(sub_sat(obs_dist, scale_mul(err, loop_cfg.beta2, 8)),
                                   scale_mul(prev_drive, loop_cfg.bgain, 8)), step, 16));
    z3 = add_sat(obs_dist,
                 scale_mul(sub_sat(0, scale_mul(err, loop_cfg.beta3, 8)), step, 16));
    obs_angle = z1;
    obs_rate  = z2;
    obs_dist  = z3;

    tgt = clip_state(longint'(loop_cfg.target) * 4);
    u = scale_mul(sub_sat(tgt, z1), loop_cfg.kp, 8);
    u = sub_sat(u, scale_mul(z2, loop_cfg.kd, 8));
    u = sub_sat(u, scale_mul(z3, loop_cfg.brecip, 24));

    // deadband is judged on the measured angle, not the estimate
    gap = longint'(loop_cfg.target) * 4 - longint'(raw) * DEG_SCALE;
    r.deadband = (gap < ladrc_pkg::DEADBAND) && (gap > -ladrc_pkg::DEADBAND);
    if (r.deadband) u = 0;
    prev_drive = u;

    q = (u >= 0) ? (u >>> 24) : -((-u) >>> 24);
    if (q > longint'(ladrc_pkg::DRIVE_MAX)) q = longint'(ladrc_pkg::DRIVE_MAX);
    if (q < longint'(ladrc_pkg::DRIVE_MIN)) q = longint'(ladrc_pkg::DRIVE_MIN);
    r.drive   = q[15:0];
    r.angle   = z1[47:0];
    r.disturb = z3[47:0];
    return r;
  endfunction

  function automatic ladrc_pkg::cfg_t default_settings();
    ladrc_pkg::cfg_t c;
    c.target = '0;
    c.kp     = ladrc_pkg::RST_PROP;
    c.kd     = ladrc_pkg::RST_RATE;
    c.beta1  = ladrc_pkg::RST_BETA1;
    c.beta2  = ladrc_pkg::RST_BETA2;
    c.beta3  = ladrc_pkg::RST_BETA3;
    c.bgain  = ladrc_pkg::RST_BGAIN;
    c.brecip = ladrc_pkg::RST_BRECIP;
    return c;
  endfunction

  function automatic logic signed [ladrc_pkg::TARGET_W-1:0] random_target();
    return ladrc_pkg::TARGET_W'(int'($urandom_range(0, 1509949440)) - 754974720);
  endfunction

  function automatic ladrc_pkg::cfg_t pick_settings(int kind);
    ladrc_pkg::cfg_t c;
    c = default_settings();
    case (kind)
      1: begin
        c.target = random_target();
        c.kp     = $urandom;
        c.kd     = $urandom;
        c.beta1  = $urandom;
        c.beta2  = $urandom;
        c.beta3  = $urandom;
        c.bgain  = $urandom_range(1, 32'hFFFF_FFFF);
        c.brecip = $urandom;
      end
      2: begin
        c.target = random_target();
        c.kp     = $urandom_range(0, 20000);
        c.kd     = $urandom_range(0, 512);
        c.beta1  = $urandom_range(0, 80000);
        c.beta2  = $urandom_range(0, 5000000);
        c.beta3  = $urandom_range(0, 120000000);
        c.bgain  = $urandom_range(256, 8000);
        c.brecip = $urandom_range(0, 70000);
      end
      3: begin
        c.target = 31'sd754974720;
        c.kp     = '1;
        c.kd     = '1;
        c.beta1  = '1;
        c.beta2  = '1;
        c.beta3  = '1;
        c.bgain  = '1;
        c.brecip = '1;
      end
      4: begin
        c.target = -31'sd754974720;
        c.kp     = '0;
        c.kd     = '0;
        c.beta1  = '0;
        c.beta2  = '0;
        c.beta3  = '0;
        c.bgain  = 32'd1;
        c.brecip = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (loop_outputs_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input ladrc_pkg::cfg_t c);
    logic [ladrc_pkg::GAIN_W-1:0] word [8];
    word[ladrc_pkg::REG_TARGET] = ladrc_pkg::GAIN_W'(c.target);
    word[ladrc_pkg::REG_PROP]   = c.kp;
    word[ladrc_pkg::REG_RATE]   = c.kd;
    word[ladrc_pkg::REG_BETA1]  = c.beta1;
    word[ladrc_pkg::REG_BETA2]  = c.beta2;
    word[ladrc_pkg::REG_BETA3]  = c.beta3;
    word[ladrc_pkg::REG_BGAIN]  = c.bgain;
    word[ladrc_pkg::REG_BRECIP] = c.brecip;
    wait_all_results();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= ladrc_pkg::REG_IDX_W'(i);
      cfg_wdata_i <= word[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    loop_cfg = c;
    settings_loaded++;
  endtask

  task automatic send_sample(input logic signed [15:0] raw, input logic [15:0] dt);
    int gap;
    gap = tx_pacing ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {dt, raw};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    loop_outputs_due.push_back(advance_loop(raw, dt));
    samples_sent++;
  endtask

  task automatic test_default_extremes();
    tx_pacing = 1'b1;
    rx_pacing = 1'b1;
    send_sample(16'sd0, 16'd0);
    send_sample(16'sd3, 16'd655);
    send_sample(-16'sd3, 16'd655);
    send_sample(16'sd4, 16'd655);
    send_sample(-16'sd4, 16'd655);
    send_sample(16'sh7fff, 16'hffff);
    send_sample(16'sh8000, 16'hffff);
    send_sample(16'sh8000, 16'd1);
    send_sample(16'sh7fff, 16'd0);
    send_sample(16'sd0, 16'd0);
    send_sample(16'sd1, 16'd1);
    send_sample(-16'sd1, 16'h8000);
  endtask

  task automatic test_deadband_edges();
    ladrc_pkg::cfg_t c;
    c = default_settings();
    c.target = ladrc_pkg::TARGET_W'(100 * 23040 + BAND_OFFSET);
    load_settings(c);
    send_sample(16'sd100, 16'd300);
    send_sample(16'sd99, 16'd300);
    c.target = ladrc_pkg::TARGET_W'(100 * 23040 + BAND_OFFSET + 1);
    load_settings(c);
    send_sample(16'sd100, 16'd300);
    send_sample(16'sd101, 16'd300);
    c.target = ladrc_pkg::TARGET_W'(-100 * 23040 - BAND_OFFSET);
    load_settings(c);
    send_sample(-16'sd100, 16'd300);
    send_sample(-16'sd99, 16'd300);
    c.target = ladrc_pkg::TARGET_W'(-100 * 23040 - BAND_OFFSET - 1);
    load_settings(c);
    send_sample(-16'sd100, 16'd300);
    send_sample(-16'sd101, 16'd300);
  endtask

  // full-scale gains, then zero gains with the smallest input gain
  task automatic test_gain_extremes();
    load_settings(pick_settings(3));
    send_sample(16'sh7fff, 16'hffff);
    send_sample(16'sh8000, 16'd100);
    send_sample(16'sd0, 16'd0);
    load_settings(pick_settings(4));
    send_sample(16'sh8000, 16'hffff);
    send_sample(16'sh7fff, 16'd1);
    send_sample(-16'sd32767, 16'd0);
  endtask

  task automatic run_sample_stream(input int count);
    int walk;
    int aim;
    int pause_at;
    logic signed [15:0] raw;
    logic [15:0]        dt;
    aim = int'(longint'(loop_cfg.target) / 23040);
    if (aim > 32767) aim = 32767;
    if (aim < -32768) aim = -32768;
    walk = aim + int'($urandom_range(0, 2000)) - 1000;
    pause_at = $urandom_range(count / 4, (3 * count) / 4);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          raw = 16'($urandom);
          dt  = 16'($urandom);
        end
        1: begin
          raw = 16'(aim + int'($urandom_range(0, 8)) - 4);
          dt  = 16'($urandom_range(0, 655));
        end
        2: begin
          raw = 16'(walk);
          dt  = 16'd0;
        end
        default: begin
          walk = walk + int'($urandom_range(0, 200)) - 100;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
          raw = 16'(walk);
          dt  = 16'($urandom_range(0, 655));
        end
      endcase
      send_sample(raw, dt);
      if (i == pause_at) wait_all_results();
    end
  endtask

  task automatic test_random_settings();
    int kinds [8];
    kinds = '{0, 2, 1, 2, 3, 2, 4, 0};
    for (int p = 0; p < 8; p++) begin
      load_settings(pick_settings(kinds[p]));
      tx_pacing = (p % 3 != 0);
      rx_pacing = (p % 4 != 1);
      run_sample_stream(165);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : rx_pace
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall = rx_pacing ? $urandom_range(0, 14) : 0;
      ready_hold    <= stall;
      m_axis_tready <= (stall == 0);
    end else if (ready_hold != 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= (ready_hold == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (loop_outputs_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        head_due = loop_outputs_due.pop_front();
        if ($signed(m_axis_tdata[15:0]) !== head_due.drive) begin
          $error("drive: expected %0d, got %0d", head_due.drive, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if ($signed(m_axis_tdata[63:16]) !== head_due.angle) begin
          $error("angle_estimate: expected %0d, got %0d", head_due.angle,
                 $signed(m_axis_tdata[63:16]));
          errors++;
        end
        if ($signed(m_axis_tdata[111:64]) !== head_due.disturb) begin
          $error("disturbance_estimate: expected %0d, got %0d", head_due.disturb,
                 $signed(m_axis_tdata[111:64]));
          errors++;
        end
        if (m_axis_tuser[0] !== head_due.deadband) begin
          $error("in_deadband: expected %0b, got %0b", head_due.deadband, m_axis_tuser[0]);
          errors++;
        end
        if (head_due.deadband) band_hits++;
        results_checked++;
      end
    end
  end

  // stall guard: no request on either stream and no register write for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    loop_cfg   = default_settings();
    obs_angle  = 0;
    obs_rate   = 0;
    obs_dist   = 0;
    prev_drive = 0;
    tx_pacing  = 1'b1;
    rx_pacing  = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_extremes();
    test_deadband_edges();
    test_gain_extremes();
    test_random_settings();

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("%0d samples sent, %0d results compared under %0d register settings",
             samples_sent, results_checked, settings_loaded);
    $display("%0d results fell in the deadband, %0d mismatches", band_hits, errors);
    if (errors == 0 && loop_outputs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
